/* rtl/core/imcs_pkg.sv */
// Shared types and constants of the in-place majority cell smoother.
`default_nettype none

package imcs_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int MIN_DIM        = 7;

  localparam int CFG_DW = 10;
  localparam int CFG_AW = 2;

  localparam int WIDTH_RST  = 300;
  localparam int HEIGHT_RST = 300;
  localparam logic [1:0] BAND_RST = 2'd3;
  localparam logic [3:0] THR_RST  = 4'd4;

  typedef logic [1:0] tile_t;

  localparam tile_t TILE_AIR  = 2'd0;
  localparam tile_t TILE_LAND = 2'd1;

  localparam logic FUNC_TILE = 1'b0;

  typedef enum logic [CFG_AW-1:0] {
    REG_MAP_WIDTH,
    REG_MAP_HEIGHT,
    REG_BORDER_BAND,
    REG_LAND_THRESHOLD
  } cfg_reg_t;

  typedef struct packed {
    logic  func;
    tile_t tile_in;
  } in_item_t;

  typedef struct packed {
    tile_t tile_out;
    logic  frame_last;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic restart;
  } line_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/inplace_majority_cell_smoother_core.sv */
// Top level of the in-place 3x3 majority smoother for a raster-order tile stream.
`default_nettype none

// The block makes one in-place smoothing pass over a tile map that arrives in
// raster order, one tile per input transaction (func = tile). Interior cells
// become land when the land count of their 3x3 window is above the threshold,
// air when it is below, and keep their value when it is equal; cells above and
// to the left are seen with their updated values. Border cells pass through.
// Each result is registered, in the output or skid register, when the input
// transaction that lies map_width+1 tiles later is accepted. Once the
// last tile of a frame is in, flush transactions (or further tiles, whose data
// is dropped) drain the remaining map_width+1 results; frame_last marks the
// final one. A flush before the last tile is accepted and dropped.
// Throughput is one transaction per cycle on both channels while the receiver
// takes every result. The window is a 3x3 array of nine cells fed by two row
// delay memories; the updated value of each cell goes back into the upper
// delay memory. When the receiver stalls, one more result is parked in a skid
// register and in_ready drops only while that register is full.
// Reset loads the register defaults (300 x 300, band 3, threshold 4) and starts
// a new frame; the delay memories are not cleared, and entries read unwritten
// reach only border cells. A write to map_width or map_height also restarts the
// frame. The user must write configuration only while idle; it is not enforced.
module inplace_majority_cell_smoother_core #(
  parameter int MAX_WIDTH  = imcs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = imcs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  imcs_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output imcs_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [imcs_pkg::CFG_AW-1:0]     cfg_idx,
  input  logic [imcs_pkg::CFG_DW-1:0]     cfg_wdata
);
  import imcs_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
  localparam int H_RST = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;

  // Configuration; the sizes are held as the last column and row index of the frame.
  logic [CW-1:0] w_last_r, w_last_nxt;
  logic [RW-1:0] h_last_r, h_last_nxt;
  logic [1:0]    band_r, band_nxt;
  logic [3:0]    thr_r, thr_nxt;
  logic [31:0]   cfg_v32;
  cfg_reg_t      cfg_reg;
  logic          frame_restart;

  assign cfg_v32 = 32'(cfg_wdata);
  assign cfg_reg = cfg_reg_t'(cfg_idx);
  assign frame_restart = cfg_we && (cfg_reg == REG_MAP_WIDTH || cfg_reg == REG_MAP_HEIGHT);

  // Out-of-range sizes are clamped at write time.
  always_comb begin
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    band_nxt   = band_r;
    thr_nxt    = thr_r;
    if (cfg_we) begin
      unique case (cfg_reg)
        REG_MAP_WIDTH: begin
          if (cfg_v32 < 32'(MIN_DIM)) begin
            w_last_nxt = CW'(MIN_DIM - 1);
          end else if (cfg_v32 > 32'(MAX_WIDTH)) begin
            w_last_nxt = CW'(MAX_WIDTH - 1);
          end else begin
            w_last_nxt = CW'(cfg_v32 - 32'd1);
          end
        end
        REG_MAP_HEIGHT: begin
          if (cfg_v32 < 32'(MIN_DIM)) begin
            h_last_nxt = RW'(MIN_DIM - 1);
          end else if (cfg_v32 > 32'(MAX_HEIGHT)) begin
            h_last_nxt = RW'(MAX_HEIGHT - 1);
          end else begin
            h_last_nxt = RW'(cfg_v32 - 32'd1);
          end
        end
        REG_BORDER_BAND:    band_nxt = cfg_wdata[1:0];
        REG_LAND_THRESHOLD: thr_nxt  = cfg_wdata[3:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= CW'(W_RST - 1);
      h_last_r <= RW'(H_RST - 1);
      band_r   <= BAND_RST;
      thr_r    <= THR_RST;
    end else begin
      w_last_r <= w_last_nxt;
      h_last_r <= h_last_nxt;
      band_r   <= band_nxt;
      thr_r    <= thr_nxt;
    end
  end

  // Handshake and stream control.
  logic in_fire, take_tile, drain, step, produce, is_final, emit_ok;
  logic out_valid_r, skid_valid_r, pop;
  out_item_t out_r, skid_r, res;

  // Input position (p) and output position (q) counters.
  logic [CW-1:0] p_col_r, p_col_nxt, q_col_r, q_col_nxt;
  logic [RW-1:0] p_row_r, p_row_nxt, q_row_r, q_row_nxt;
  logic          done_r, done_nxt;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign take_tile = in_fire && (in_data.func == FUNC_TILE) && !done_r;
  // Once the frame is in, every transaction is a drain tick.
  assign drain     = in_fire && done_r;
  assign step      = take_tile || drain;
  // Results start once tile width+1 of the frame arrives.
  assign emit_ok   = (p_row_r > RW'(1)) || (p_row_r == RW'(1) && p_col_r != '0);
  assign produce   = drain || (take_tile && emit_ok);
  assign is_final  = (q_col_r == w_last_r) && (q_row_r == h_last_r);

  always_comb begin
    p_col_nxt = p_col_r;
    p_row_nxt = p_row_r;
    q_col_nxt = q_col_r;
    q_row_nxt = q_row_r;
    done_nxt  = done_r;
    priority if (frame_restart || (produce && is_final)) begin
      p_col_nxt = '0;
      p_row_nxt = '0;
      q_col_nxt = '0;
      q_row_nxt = '0;
      done_nxt  = 1'b0;
    end else begin
      if (take_tile) begin
        if (p_col_r == w_last_r) begin
          p_col_nxt = '0;
          if (p_row_r == h_last_r) begin
            // Last tile in: the row counter parks at zero while draining.
            p_row_nxt = '0;
            done_nxt  = 1'b1;
          end else begin
            p_row_nxt = p_row_r + RW'(1);
          end
        end else begin
          p_col_nxt = p_col_r + CW'(1);
        end
      end
      if (produce) begin
        if (q_col_r == w_last_r) begin
          q_col_nxt = '0;
          q_row_nxt = q_row_r + RW'(1);
        end else begin
          q_col_nxt = q_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_col_r <= '0;
      p_row_r <= '0;
      q_col_r <= '0;
      q_row_r <= '0;
      done_r  <= 1'b0;
    end else begin
      p_col_r <= p_col_nxt;
      p_row_r <= p_row_nxt;
      q_col_r <= q_col_nxt;
      q_row_r <= q_row_nxt;
      done_r  <= done_nxt;
    end
  end

  // Window: bottom row holds original tiles p-2, p-1, p; the middle row holds
  // updated q-1 and original q, q+1; the top row holds updated q-w-1 .. q-w+1.
  line_ctl_t     line_ctl;
  logic [CW-1:0] line1_last, line2_last;
  tile_t         mid_right, top_right;
  tile_t         bot_left, bot_center, mid_left, mid_center, top_left, top_center;
  logic [8:0]    land;
  tile_t         upd;

  assign line_ctl.shift   = step;
  assign line_ctl.restart = frame_restart;
  // The original row is delayed by width-1 shifts, the updated row by width-2,
  // each with one more register at the read port.
  assign line1_last = w_last_r - CW'(1);
  assign line2_last = w_last_r - CW'(2);

  imcs_line #(.DEPTH(MAX_WIDTH)) u_line_orig (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (line_ctl),
    .last (line1_last),
    .din  (in_data.tile_in),
    .dout (mid_right)
  );

  imcs_line #(.DEPTH(MAX_WIDTH)) u_line_upd (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (line_ctl),
    .last (line2_last),
    .din  (upd),
    .dout (top_right)
  );

  imcs_cell u_bot_center (.clk(clk), .en(step), .d(in_data.tile_in), .q(bot_center));
  imcs_cell u_bot_left   (.clk(clk), .en(step), .d(bot_center), .q(bot_left));
  imcs_cell u_mid_center (.clk(clk), .en(step), .d(mid_right), .q(mid_center));
  imcs_cell u_mid_left   (.clk(clk), .en(step), .d(upd), .q(mid_left));
  imcs_cell u_top_center (.clk(clk), .en(step), .d(top_right), .q(top_center));
  imcs_cell u_top_left   (.clk(clk), .en(step), .d(top_center), .q(top_left));

  assign land[0] = (top_left == TILE_LAND);
  assign land[1] = (top_center == TILE_LAND);
  assign land[2] = (top_right == TILE_LAND);
  assign land[3] = (mid_left == TILE_LAND);
  assign land[4] = (mid_center == TILE_LAND);
  assign land[5] = (mid_right == TILE_LAND);
  assign land[6] = (bot_left == TILE_LAND);
  assign land[7] = (bot_center == TILE_LAND);
  assign land[8] = (in_data.tile_in == TILE_LAND);

  // Majority decision for cell q.
  logic [3:0]    cnt;
  logic [1:0]    band_eff;
  logic [CW:0]   col_hi;
  logic [RW:0]   row_hi;
  logic          interior;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < 9; i++) begin
      cnt = cnt + 4'(land[i]);
    end
  end

  // A zero band acts as a band of one.
  assign band_eff = (band_r == 2'd0) ? 2'd1 : band_r;
  assign col_hi   = {1'b0, q_col_r} + (CW+1)'(band_eff);
  assign row_hi   = {1'b0, q_row_r} + (RW+1)'(band_eff);
  assign interior = (q_col_r >= CW'(band_eff)) && (col_hi <= {1'b0, w_last_r}) &&
                    (q_row_r >= RW'(band_eff)) && (row_hi <= {1'b0, h_last_r});

  always_comb begin
    upd = mid_center;
    if (interior) begin
      if (cnt > thr_r) begin
        upd = TILE_LAND;
      end else if (cnt < thr_r) begin
        upd = TILE_AIR;
      end
    end
  end

  assign res.tile_out   = upd;
  assign res.frame_last = is_final;

  // Output register with one skid entry behind it.
  assign pop = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (produce) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (produce) begin
      if (!out_valid_r || pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while the output register is empty");

  a_done_parks_input: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (p_col_r == '0 && p_row_r == '0))
    else $error("input position moved after the frame was complete");

  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (produce && is_final) |=> (q_col_r == '0 && q_row_r == '0 && !done_r))
    else $error("frame did not restart after its final result");

  a_final_only_draining: assert property (@(posedge clk) disable iff (!rst_n)
    (produce && is_final) |-> drain)
    else $error("final result produced before the frame was complete");

  a_q_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    q_row_r <= h_last_r)
    else $error("output row beyond the frame");
`endif

endmodule

`default_nettype wire

/* rtl/core/imcs_cell.sv */
// One window cell: holds a tile, takes its neighbor's tile on every shift.
`default_nettype none

module imcs_cell (
  input  logic           clk,
  input  logic           en,
  input  imcs_pkg::tile_t d,
  output imcs_pkg::tile_t q
);
  import imcs_pkg::*;

  tile_t tile_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tile_r <= d;
    end
  end

  assign q = tile_r;

endmodule

`default_nettype wire

/* rtl/core/imcs_line.sv */
// Row delay line: a circular memory with a registered read, one entry per shift.
`default_nettype none

module imcs_line #(
  parameter int DEPTH = imcs_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  imcs_pkg::line_ctl_t      ctl,
  input  logic [$clog2(DEPTH)-1:0] last,
  input  imcs_pkg::tile_t          din,
  output imcs_pkg::tile_t          dout
);
  import imcs_pkg::*;

  localparam int AW = $clog2(DEPTH);

  tile_t         mem [DEPTH];
  tile_t         rd_r;
  logic [AW-1:0] ptr_r;
  logic [AW-1:0] ptr_nxt;

  // The pointer wraps after last, so the delay is last+1 shifts.
  always_comb begin
    ptr_nxt = ptr_r;
    if (ctl.restart) begin
      ptr_nxt = '0;
    end else if (ctl.shift) begin
      if (ptr_r >= last) begin
        ptr_nxt = '0;
      end else begin
        ptr_nxt = ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  // Read before write at the same address.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      rd_r       <= mem[ptr_r];
      mem[ptr_r] <= din;
    end
  end

  assign dout = rd_r;

endmodule

`default_nettype wire
